### design/pss_pkg.sv
// Shared package for the parity split sorter.
// Holds default sizes and the command/status words between controller and datapath.
// No dependencies.
package pss_pkg;

	localparam int DEF_STORE_DEPTH = 16;
	localparam int DEF_DATA_WIDTH  = 32;

	typedef struct packed {
		logic file;    // write the input word into its list
		logic pop;     // move the next sorted word into the output register
		logic finish;  // close the batch
	} pss_cmd_t;

	typedef struct packed {
		logic even_left;
		logic odd_left;
		logic out_room;
		logic last_one;
	} pss_status_t;

endpackage

### design/pss_list.sv
// One sorted list of the parity split sorter: insertion on write, shift out at the head.
// Depends on nothing but its parameters.
module pss_list #(
	parameter int DEPTH   = 16,
	parameter int WIDTH   = 32,
	parameter bit DESCEND = 1'b0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          ins,
	input  logic signed [WIDTH-1:0]       ins_data,
	input  logic                          pop,
	output logic signed [WIDTH-1:0]       head,
	output logic [$clog2(DEPTH+1)-1:0]    count,
	output logic                          full
);
	localparam int CW = $clog2(DEPTH + 1);

	logic signed [WIDTH-1:0] cell_q [DEPTH];
	logic [CW-1:0]           count_q;
	logic [DEPTH-1:0]        keep;

	assign head  = cell_q[0];
	assign count = count_q;
	assign full  = (count_q == CW'(DEPTH));

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign keep[i] = (CW'(i) < count_q) &&
			(DESCEND ? (cell_q[i] >= ins_data) : (cell_q[i] <= ins_data));

		always_ff @(posedge clk) begin
			if (ins && !full) begin
				if (!keep[i]) begin
					if (i == 0)
						cell_q[i] <= ins_data;
					else if (keep[(i == 0) ? 0 : i-1])
						cell_q[i] <= ins_data;
					else
						cell_q[i] <= cell_q[(i == 0) ? 0 : i-1];
				end
			end else if (pop) begin
				if (i < DEPTH-1)
					cell_q[i] <= cell_q[(i < DEPTH-1) ? i+1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ins && !full) begin
			count_q <= count_q + CW'(1);
		end else if (pop && count_q != '0) begin
			count_q <= count_q - CW'(1);
		end
	end

endmodule

### design/pss_ctrl.sv
// Controller of the parity split sorter: file words, then drain the two lists.
// Depends on pss_pkg.
module pss_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 batch_end,
	output logic                 in_stall,
	input  pss_pkg::pss_status_t status,
	output pss_pkg::pss_cmd_t    cmd
);
	import pss_pkg::*;

	typedef enum logic {ST_LOAD, ST_EMIT} state_t;

	state_t state_q;

	assign in_stall = (state_q != ST_LOAD);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_LOAD: begin
				cmd.file = in_valid;
			end
			ST_EMIT: begin
				cmd.pop    = status.out_room && (status.even_left || status.odd_left);
				cmd.finish = (cmd.pop && status.last_one) ||
					(!status.even_left && !status.odd_left);
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			case (state_q)
				ST_LOAD: if (cmd.file && batch_end) state_q <= ST_EMIT;
				ST_EMIT: if (cmd.finish) state_q <= ST_LOAD;
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

### design/pss_dp.sv
// Datapath of the parity split sorter: even and odd lists, drop flag, output register.
// Depends on pss_pkg and pss_list.
module pss_dp #(
	parameter int STORE_DEPTH = pss_pkg::DEF_STORE_DEPTH,
	parameter int DATA_WIDTH  = pss_pkg::DEF_DATA_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [DATA_WIDTH-1:0] value,
	input  pss_pkg::pss_cmd_t            cmd,
	output pss_pkg::pss_status_t         status,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic signed [DATA_WIDTH-1:0] sorted_value,
	output logic                         is_even,
	output logic                         run_end,
	output logic                         dropped
);
	import pss_pkg::*;

	localparam int CW = $clog2(STORE_DEPTH + 1);

	logic signed [DATA_WIDTH-1:0] even_head, odd_head;
	logic [CW-1:0]                even_cnt, odd_cnt;
	logic                         even_full, odd_full;
	logic                         overflow_q;
	logic                         out_valid_q;
	logic signed [DATA_WIDTH-1:0] value_q;
	logic                         is_even_q, run_end_q, dropped_q;
	logic                         even_pop, odd_pop;

	assign even_pop = cmd.pop && (even_cnt != '0);
	assign odd_pop  = cmd.pop && (even_cnt == '0);

	pss_list #(.DEPTH(STORE_DEPTH), .WIDTH(DATA_WIDTH), .DESCEND(1'b0)) u_even (
		.clk(clk), .arst_n(arst_n),
		.ins(cmd.file && !value[0]), .ins_data(value), .pop(even_pop),
		.head(even_head), .count(even_cnt), .full(even_full)
	);

	pss_list #(.DEPTH(STORE_DEPTH), .WIDTH(DATA_WIDTH), .DESCEND(1'b1)) u_odd (
		.clk(clk), .arst_n(arst_n),
		.ins(cmd.file && value[0]), .ins_data(value), .pop(odd_pop),
		.head(odd_head), .count(odd_cnt), .full(odd_full)
	);

	assign status.even_left = (even_cnt != '0);
	assign status.odd_left  = (odd_cnt != '0);
	assign status.out_room  = !out_valid_q || !out_stall;
	assign status.last_one  = (({1'b0, even_cnt} + {1'b0, odd_cnt}) == (CW+1)'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overflow_q <= 1'b0;
		end else if (cmd.finish) begin
			overflow_q <= 1'b0;
		end else if (cmd.file && (value[0] ? odd_full : even_full)) begin
			overflow_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			value_q   <= even_pop ? even_head : odd_head;
			is_even_q <= even_pop;
			run_end_q <= status.last_one;
			dropped_q <= overflow_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sorted_value = value_q;
	assign is_even      = is_even_q;
	assign run_end      = run_end_q;
	assign dropped      = dropped_q;

endmodule

### design/parity_split_sorter_unit.sv
// Parity split sorter, top level.
// Input channel: value and batch_end with in_valid / in_stall. Each word is filed by its
// lowest bit into an even list (kept ascending) or an odd list (kept descending), one word
// per cycle while in_stall is low. A word whose list already holds STORE_DEPTH entries
// is dropped and marks the batch as dropped.
// Output channel: sorted_value, is_even, run_end, dropped with out_valid / out_stall.
// After the batch_end word is taken, in_stall rises and the lists drain through the output
// register: all even words ascending, then all odd words descending, run_end on the last.
// Taking the batch_end word moves the controller into its emit state; from there the
// first result is loaded into the output register, then one result per cycle while
// out_stall is low. At most 2*STORE_DEPTH words are stored per batch. When out_stall is
// high the output word holds and draining pauses. in_stall falls once the last result
// has entered the output register; the next batch may load meanwhile.
// Reset empties both lists, clears the drop mark and the output valid.
// Depends on pss_pkg, pss_ctrl and pss_dp.
module parity_split_sorter_unit #(
	parameter int STORE_DEPTH = pss_pkg::DEF_STORE_DEPTH,
	parameter int DATA_WIDTH  = pss_pkg::DEF_DATA_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] value,
	input  logic                         batch_end,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] sorted_value,
	output logic                         is_even,
	output logic                         run_end,
	output logic                         dropped
);
	import pss_pkg::*;

	pss_cmd_t    cmd;
	pss_status_t status;

	pss_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .batch_end(batch_end), .in_stall(in_stall),
		.status(status), .cmd(cmd)
	);

	pss_dp #(.STORE_DEPTH(STORE_DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.value(value), .cmd(cmd), .status(status),
		.out_stall(out_stall), .out_valid(out_valid),
		.sorted_value(sorted_value), .is_even(is_even),
		.run_end(run_end), .dropped(dropped)
	);

endmodule
